### src/obepm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obepm_pkg: shared types and constants of the exact-price order matcher
// Request and response beats, result kinds, controller/datapath command and status.
// ----------------------------------------------------------------------------
package obepm_pkg;

   localparam int unsigned ID_W    = 16;
   localparam int unsigned INSTR_W = 16;
   localparam int unsigned QTY_W   = 31;
   localparam int unsigned PRICE_W = 31;
   localparam int unsigned OWNER_W = 16;
   localparam int unsigned SESS_W  = 64;
   localparam int unsigned KIND_W  = 3;

   localparam logic CMD_SUBMIT = 1'b0;
   localparam logic CMD_CANCEL = 1'b1;

   localparam logic [KIND_W-1:0] KIND_TRADE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CANCEL_OK = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NOT_OWNER = 3'd5;
   localparam logic [KIND_W-1:0] KIND_GONE      = 3'd6;

   typedef struct packed {
      logic               cmd;
      logic               is_buy;
      logic [INSTR_W-1:0] instrument;
      logic [QTY_W-1:0]   qty;
      logic [PRICE_W-1:0] price;
      logic [OWNER_W-1:0] owner;
      logic [SESS_W-1:0]  session;
      logic [ID_W-1:0]    cancel_id;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    assigned_id;
      logic [INSTR_W-1:0] instrument_res;
      logic [QTY_W-1:0]   qty_res;
      logic [PRICE_W-1:0] price_res;
      logic [OWNER_W-1:0] buy_owner;
      logic [SESS_W-1:0]  buy_sess;
      logic [OWNER_W-1:0] sell_owner;
      logic [SESS_W-1:0]  sell_sess;
      logic               last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch request, clear scan index
      logic read_slot;   // read slot at scan index (or cancel target)
      logic eval_slot;   // evaluate read data, maybe emit trade
      logic book;        // write new order, emit accept
      logic reject;      // emit reject
      logic cancel_eval; // decide cancel result from read data
      logic not_found;   // emit not found
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_cancel;
      logic full;
      logic in_range;
      logic scan_done;
   } sts_type;

endpackage

### src/order_book_exact_price_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_exact_price_matcher_core: exact-price limit order book
// Submit and cancel commands against a book of ORDERS slots.
// ----------------------------------------------------------------------------
// A command beat is taken on start while busy is low. Results come out on
// rsp_strobe, one beat per cycle at most, and the receiver cannot stall them;
// rsp.last marks the final beat of a command.
// A submit walks the issued slots in order, a memory read (ST_READ) then a
// compare and fill (ST_EVAL) per slot, until the quantity runs out or the
// issued slots end; a booking submit sees at most ORDERS-1 issued slots.
// Trades come first, then the accept beat. A cancel reads its target in
// ST_DECODE and decides in ST_CEVAL; a reject or not-found is decided in
// ST_DECODE. busy falls in the cycle of the final beat, so the next command
// can be taken at the edge that ends it. The slot memory's single read port
// paces the scan.
// Reset clears the id counter and the controller; slot contents need no
// clearing since only issued slots are read.
// ----------------------------------------------------------------------------
module order_book_exact_price_matcher_core
   import obepm_pkg::*;
#(
   parameter int unsigned ORDERS   = 64,
   parameter int unsigned FIRST_ID = 1
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_beat,
   output logic    rsp_strobe,
   output rsp_type rsp_beat
);

   ctl_type ctl;
   sts_type sts;

   obepm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .ctl   (ctl)
   );

   obepm_datapath #(
      .ORDERS   (ORDERS),
      .FIRST_ID (FIRST_ID)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_in     (req_beat),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_beat)
   );

endmodule

### src/obepm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obepm_datapath: order slot memory, scan index and result register
// Holds the request, reads one slot at a time and forms trade and status beats.
// ----------------------------------------------------------------------------
module obepm_datapath
   import obepm_pkg::*;
#(
   parameter int unsigned ORDERS   = 64,
   parameter int unsigned FIRST_ID = 1
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_in,
   input  ctl_type ctl,
   output sts_type sts,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   localparam int unsigned SW = $clog2(ORDERS);
   localparam int unsigned CW = $clog2(ORDERS + 1);

   typedef struct packed {
      logic [QTY_W-1:0]   remaining;
      logic [PRICE_W-1:0] price;
      logic [INSTR_W-1:0] instrument;
      logic               is_buy;
      logic [OWNER_W-1:0] owner;
      logic [SESS_W-1:0]  session;
   } slot_type;

   slot_type slot_mem [ORDERS];
   slot_type rd_ff;
   logic [SW-1:0] rd_addr_ff;

   req_type       req_ff;
   logic [CW-1:0] next_slot_ff, next_slot_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [QTY_W-1:0] rem_ff, rem_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [ID_W:0] id_off;
   logic [CW-1:0] target;
   logic          match;
   logic [QTY_W-1:0] tq;
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   slot_type      wr_data;

   assign id_off = {1'b0, req_ff.cancel_id} - (ID_W+1)'(FIRST_ID);
   assign target = id_off[CW-1:0];

   assign sts.is_cancel = req_ff.cmd == CMD_CANCEL;
   assign sts.full      = next_slot_ff == CW'(ORDERS);
   assign sts.in_range  = !id_off[ID_W] && (id_off < (ID_W+1)'(next_slot_ff));
   assign sts.scan_done = (scan_ff >= next_slot_ff) || (rem_ff == '0);

   assign match = (rd_ff.remaining != '0) && (rd_ff.is_buy != req_ff.is_buy) &&
                  (rd_ff.instrument == req_ff.instrument) &&
                  (rd_ff.price == req_ff.price);
   assign tq = (rem_ff < rd_ff.remaining) ? rem_ff : rd_ff.remaining;

   always_comb begin
      next_slot_in  = next_slot_ff;
      scan_in       = scan_ff;
      rem_in        = rem_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      wr_en         = 1'b0;
      wr_addr       = rd_addr_ff;
      wr_data       = rd_ff;
      if (ctl.capture) begin
         scan_in = '0;
         rem_in  = req_in.qty;
      end
      if (ctl.read_slot && !sts.is_cancel) begin
         scan_in = scan_ff + CW'(1);
      end
      if (ctl.eval_slot && match) begin
         rem_in             = rem_ff - tq;
         wr_en              = 1'b1;
         wr_data.remaining  = rd_ff.remaining - tq;
         rsp_strobe_in      = 1'b1;
         rsp_in.kind        = KIND_TRADE;
         rsp_in.instrument_res = req_ff.instrument;
         rsp_in.qty_res     = tq;
         rsp_in.price_res   = req_ff.price;
         if (req_ff.is_buy) begin
            rsp_in.buy_owner  = req_ff.owner;
            rsp_in.buy_sess   = req_ff.session;
            rsp_in.sell_owner = rd_ff.owner;
            rsp_in.sell_sess  = rd_ff.session;
         end else begin
            rsp_in.buy_owner  = rd_ff.owner;
            rsp_in.buy_sess   = rd_ff.session;
            rsp_in.sell_owner = req_ff.owner;
            rsp_in.sell_sess  = req_ff.session;
         end
      end
      if (ctl.book) begin
         wr_en              = 1'b1;
         wr_addr            = next_slot_ff[SW-1:0];
         wr_data.remaining  = rem_ff;
         wr_data.price      = req_ff.price;
         wr_data.instrument = req_ff.instrument;
         wr_data.is_buy     = req_ff.is_buy;
         wr_data.owner      = req_ff.owner;
         wr_data.session    = req_ff.session;
         next_slot_in       = next_slot_ff + CW'(1);
         rsp_strobe_in      = 1'b1;
         rsp_in.kind        = KIND_ACCEPTED;
         rsp_in.assigned_id = ID_W'(FIRST_ID) + ID_W'(next_slot_ff);
         rsp_in.last        = 1'b1;
      end
      if (ctl.reject) begin
         rsp_strobe_in = 1'b1;
         rsp_in.kind   = KIND_REJECTED;
         rsp_in.last   = 1'b1;
      end
      if (ctl.not_found) begin
         rsp_strobe_in = 1'b1;
         rsp_in.kind   = KIND_NOT_FOUND;
         rsp_in.last   = 1'b1;
      end
      if (ctl.cancel_eval) begin
         rsp_strobe_in = 1'b1;
         rsp_in.last   = 1'b1;
         if (rd_ff.session != req_ff.session) begin
            rsp_in.kind = KIND_NOT_OWNER;
         end else if (rd_ff.remaining == '0) begin
            rsp_in.kind = KIND_GONE;
         end else begin
            rsp_in.kind       = KIND_CANCEL_OK;
            wr_en             = 1'b1;
            wr_data.remaining = '0;
         end
      end
   end

   // slot memory: one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (ctl.read_slot) begin
         rd_ff      <= slot_mem[sts.is_cancel ? target[SW-1:0] : scan_ff[SW-1:0]];
         rd_addr_ff <= sts.is_cancel ? target[SW-1:0] : scan_ff[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_in;
      end
      scan_ff <= scan_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         next_slot_ff  <= next_slot_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

### src/obepm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obepm_ctrl: command sequencer of the order matcher
// Steps a submit through the slot scan and booking, a cancel through its checks.
// ----------------------------------------------------------------------------
module obepm_ctrl
   import obepm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output ctl_type ctl
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_READ   = 5'b00100,
      ST_EVAL   = 5'b01000,
      ST_CEVAL  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_cancel) begin
               if (sts.in_range) begin
                  ctl.read_slot = 1'b1;
                  state_in      = ST_CEVAL;
               end else begin
                  ctl.not_found = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (sts.full) begin
               ctl.reject = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.scan_done) begin
               ctl.book = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ctl.read_slot = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ctl.eval_slot = 1'b1;
            state_in      = ST_READ;
         end
         ST_CEVAL: begin
            ctl.cancel_eval = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the exact-price order book matcher
// Drives submit and cancel commands through a table of directed beats, then
// random order flow, and checks every result beat against a book model.
// ----------------------------------------------------------------------------
module tb;
   import obepm_pkg::*;

   localparam int unsigned ORDERS    = 64;
   localparam int unsigned FIRST_ID  = 1;
   localparam int unsigned N_RANDOM  = 146;
   localparam int unsigned N_DIRECT  = 14;
   localparam int unsigned EXP_DEPTH = 1024;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_beat;
   logic    rsp_strobe;
   rsp_type rsp_beat;

   order_book_exact_price_matcher_core #(
      .ORDERS(ORDERS),
      .FIRST_ID(FIRST_ID)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_beat(req_beat),
      .rsp_strobe(rsp_strobe),
      .rsp_beat(rsp_beat)
   );

   // book model
   int unsigned      ids_issued;
   logic [QTY_W-1:0]   bk_remaining [ORDERS];
   logic [PRICE_W-1:0] bk_price     [ORDERS];
   logic [INSTR_W-1:0] bk_instrument[ORDERS];
   logic               bk_is_buy    [ORDERS];
   logic [OWNER_W-1:0] bk_owner     [ORDERS];
   logic [SESS_W-1:0]  bk_session   [ORDERS];

   // expected result beats, written at exp_wr and drained at exp_rd
   rsp_type     exp_mem [EXP_DEPTH];
   int unsigned exp_wr = 0;
   int unsigned exp_rd = 0;
   int      errors;
   int      beats_checked;
   int      trades_seen;
   int      kind_count[8];

   function automatic void exp_put(rsp_type r);
      exp_mem[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endfunction

   function automatic rsp_type simple_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.assigned_id = id;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic book_command(input req_type c);
      int unsigned      slot;
      int unsigned      me;
      logic [QTY_W-1:0] rem;
      logic [QTY_W-1:0] fill;
      rsp_type          t;
      if (c.cmd == CMD_CANCEL) begin
         if (c.cancel_id < FIRST_ID || c.cancel_id - FIRST_ID >= ids_issued) begin
            exp_put(simple_result(KIND_NOT_FOUND, '0));
         end else begin
            slot = c.cancel_id - FIRST_ID;
            if (bk_session[slot] != c.session)
               exp_put(simple_result(KIND_NOT_OWNER, '0));
            else if (bk_remaining[slot] == 0)
               exp_put(simple_result(KIND_GONE, '0));
            else begin
               bk_remaining[slot] = '0;
               exp_put(simple_result(KIND_CANCEL_OK, '0));
            end
         end
      end else if (ids_issued >= ORDERS) begin
         exp_put(simple_result(KIND_REJECTED, '0));
      end else begin
         me = ids_issued;
         rem = c.qty;
         ids_issued++;
         for (slot = 0; slot < me && rem > 0; slot++) begin
            if (bk_remaining[slot] == 0 || bk_is_buy[slot] == c.is_buy ||
                bk_instrument[slot] != c.instrument || bk_price[slot] != c.price)
               continue;
            fill = (rem < bk_remaining[slot]) ? rem : bk_remaining[slot];
            rem -= fill;
            bk_remaining[slot] -= fill;
            t = '0;
            t.kind = KIND_TRADE;
            t.instrument_res = c.instrument;
            t.qty_res = fill;
            t.price_res = c.price;
            if (c.is_buy) begin
               t.buy_owner = c.owner;   t.buy_sess = c.session;
               t.sell_owner = bk_owner[slot]; t.sell_sess = bk_session[slot];
            end else begin
               t.buy_owner = bk_owner[slot];  t.buy_sess = bk_session[slot];
               t.sell_owner = c.owner;  t.sell_sess = c.session;
            end
            exp_put(t);
         end
         bk_remaining[me]  = rem;
         bk_price[me]      = c.price;
         bk_instrument[me] = c.instrument;
         bk_is_buy[me]     = c.is_buy;
         bk_owner[me]      = c.owner;
         bk_session[me]    = c.session;
         exp_put(simple_result(KIND_ACCEPTED, ID_W'(FIRST_ID + me)));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         beats_checked++;
         kind_count[rsp_beat.kind]++;
         if (rsp_beat.kind == KIND_TRADE) trades_seen++;
         if (exp_wr == exp_rd) begin
            errors++;
            $display("%0t: unexpected result beat %p", $time, rsp_beat);
         end else begin
            want = exp_mem[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_beat !== want) begin
               errors++;
               $display("%0t: result mismatch expected %p actual %p", $time, want, rsp_beat);
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   // directed beats; expected kind given where obvious, else left to the model
   req_type         direct_cmd [N_DIRECT];
   logic [KIND_W-1:0] direct_kind[N_DIRECT];
   logic              direct_has_kind[N_DIRECT];

   function automatic req_type mk(logic cmd, logic buy, logic [15:0] instr, logic [30:0] qty,
                                  logic [30:0] price, logic [15:0] owner, logic [63:0] sess,
                                  logic [15:0] id);
      req_type r;
      r.cmd = cmd; r.is_buy = buy; r.instrument = instr; r.qty = qty; r.price = price;
      r.owner = owner; r.session = sess; r.cancel_id = id;
      return r;
   endfunction

   task automatic send(input req_type c);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      while (busy) @(negedge clock);
      req_beat <= c;
      start    <= 1'b1;
      @(posedge clock);
      book_command(c);
      @(negedge clock);
      start    <= 1'b0;
      req_beat <= '0;
   endtask

   function automatic req_type random_command(int unsigned nprice);
      req_type c;
      c = mk(CMD_SUBMIT, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 2)),
             31'($urandom_range(1, 20)), 31'($urandom_range(100, 100 + nprice)),
             16'($urandom_range(0, 3)), 64'($urandom_range(0, 3)), 16'd0);
      case ($urandom_range(0, 9))
         0: begin
            c.instrument = 16'($urandom); c.qty = 31'($urandom); c.price = 31'($urandom);
            c.owner = 16'($urandom); c.session = {$urandom, $urandom};
         end
         1, 2, 3: begin
            c.cmd = CMD_CANCEL;
            c.cancel_id = (ids_issued > 0) ?
                          16'(FIRST_ID + $urandom_range(0, ids_issued - 1)) : 16'd0;
            if ($urandom_range(0, 4) == 0) c.cancel_id = 16'($urandom);
            if ($urandom_range(0, 4) == 0) c.session = {$urandom, $urandom};
         end
         4: c.qty = '0;
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      int i;
      int unsigned row_first;
      errors = 0; beats_checked = 0; trades_seen = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
      ids_issued = 0;
      start = 1'b0;
      req_beat = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      direct_cmd[0]  = mk(CMD_CANCEL, 0, 0, 0, 0, 0, 0, 16'd0);          // nothing issued yet
      direct_cmd[1]  = mk(CMD_CANCEL, 0, 0, 0, 0, 0, 0, 16'hFFFF);
      direct_cmd[2]  = mk(CMD_SUBMIT, 0, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
      direct_cmd[3]  = mk(CMD_SUBMIT, 1, 16'hFFFF, 31'h7FFF_FFFE, 31'h7FFF_FFFF, 16'h1234,
                          64'h0123_4567_89AB_CDEF, 0);
      direct_cmd[4]  = mk(CMD_SUBMIT, 1, 16'hFFFF, 31'd5, 31'h7FFF_FFFF, 16'h0, 64'h0, 0);
      direct_cmd[5]  = mk(CMD_SUBMIT, 0, 0, 31'd0, 31'd0, 0, 64'd7, 0);  // zero quantity
      direct_cmd[6]  = mk(CMD_CANCEL, 0, 0, 0, 0, 0, 64'd7, 16'd4);
      direct_cmd[7]  = mk(CMD_SUBMIT, 1, 16'd9, 31'd50, 31'd77, 16'd3, 64'd9, 0);
      direct_cmd[8]  = mk(CMD_CANCEL, 0, 0, 0, 0, 0, 64'd8, 16'd5);      // wrong session
      direct_cmd[9]  = mk(CMD_CANCEL, 0, 0, 0, 0, 0, 64'd9, 16'd5);
      direct_cmd[10] = mk(CMD_CANCEL, 0, 0, 0, 0, 0, 64'd9, 16'd5);      // already gone
      direct_cmd[11] = mk(CMD_SUBMIT, 0, 16'd9, 31'd50, 31'd76, 16'd3, 64'd9, 0); // books a sell at 76; no match
      direct_cmd[12] = mk(CMD_SUBMIT, 1, 16'd9, 31'd20, 31'd76, 16'd3, 64'd9, 0); // self trade
      direct_cmd[13] = mk(CMD_CANCEL, 0, 0, 0, 0, 0, 64'd9, 16'd6);
      foreach (direct_has_kind[k]) direct_has_kind[k] = 1'b0;
      direct_kind[0] = KIND_NOT_FOUND;  direct_has_kind[0] = 1'b1;
      direct_kind[1] = KIND_NOT_FOUND;  direct_has_kind[1] = 1'b1;
      direct_kind[2] = KIND_ACCEPTED;   direct_has_kind[2] = 1'b1;
      direct_kind[6] = KIND_GONE;       direct_has_kind[6] = 1'b1;
      direct_kind[8] = KIND_NOT_OWNER;  direct_has_kind[8] = 1'b1;
      direct_kind[9] = KIND_CANCEL_OK;  direct_has_kind[9] = 1'b1;
      direct_kind[10] = KIND_GONE;      direct_has_kind[10] = 1'b1;

      for (i = 0; i < N_DIRECT; i++) begin
         row_first = exp_wr;
         send(direct_cmd[i]);
         if (direct_has_kind[i] && exp_mem[row_first % EXP_DEPTH].kind != direct_kind[i]) begin
            errors++;
            $display("%0t: directed row %0d expected kind %0d, model gives %0d", $time, i,
                     direct_kind[i], exp_mem[row_first % EXP_DEPTH].kind);
         end
      end

      // random flow; book fills up at ORDERS ids, after which submits are rejected
      for (i = 0; i < N_RANDOM; i++)
         send(random_command((i < 80) ? 2 : 6));

      while (exp_wr != exp_rd) @(negedge clock);
      repeat (2 * ORDERS + 10) @(negedge clock);

      $display("covered %0d commands, %0d result beats, %0d trades, %0d rejects",
               N_DIRECT + N_RANDOM, beats_checked, trades_seen, kind_count[KIND_REJECTED]);
      if (errors == 0 && exp_wr == exp_rd)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### order_book_exact_price_matcher_core.f
src/obepm_pkg.sv
src/obepm_datapath.sv
src/obepm_ctrl.sv
src/order_book_exact_price_matcher_core.sv
verif/tb.sv
